@@ src/tblr_pkg.sv @@
// shared types and constants of the tile background line renderer
`default_nettype none

package tblr_pkg;

    // input operation codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_VRAM_WR = 3'd1;
    localparam logic [2:0] OP_CTRL_WR = 3'd2;
    localparam logic [2:0] OP_SCY_WR  = 3'd3;
    localparam logic [2:0] OP_SCX_WR  = 3'd4;

    // line timing
    localparam logic [8:0] TICK_LIMIT    = 9'd279;
    localparam logic [7:0] LAST_LINE     = 8'd153;
    localparam logic [7:0] VISIBLE_LINES = 8'd144;
    localparam logic [7:0] LINE_AT_RESET = 8'd144;
    localparam int         DISPLAY_ON_BIT = 7;

    // tiles across one line
    localparam logic [4:0] LAST_TILE = 5'd19;

    // background map at offset 0x1800: top two address bits set
    localparam logic [1:0] MAP_BASE_HI = 2'b11;

    // command passed from the front to the back
    typedef struct packed {
        logic        is_render;
        logic [12:0] address;
        logic [7:0]  data;
        logic [7:0]  line;
        logic [7:0]  scroll_y;
        logic [4:0]  first_col;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

@@ src/tblr_in_if.sv @@
// input channel interface: operation, address and data
`default_nettype none

interface tblr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [12:0] address;
    logic [7:0]  data;

    modport source (output valid, output operation, output address, output data,
                    input ready);
    modport sink   (input valid, input operation, input address, input data,
                    output ready);
endinterface

`default_nettype wire

@@ src/tblr_out_if.sv @@
// result channel interface: one rendered tile row
`default_nettype none

interface tblr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line;
    logic [4:0] tile_column;
    logic [7:0] dark_mask;
    logic       last;

    modport source (output valid, output line, output tile_column, output dark_mask,
                    output last, input ready);
    modport sink   (input valid, input line, input tile_column, input dark_mask,
                    input last, output ready);
endinterface

`default_nettype wire

@@ src/tblr_cmd_fifo.sv @@
// command queue between front and back
`default_nettype none

module tblr_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  tblr_pkg::cmd_t         push_cmd,
    input  wire logic              pop,
    output tblr_pkg::cmd_t         head,
    output tblr_pkg::fifo_stat_t   stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tblr_pkg::cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/tblr_front.sv @@
// front end: register writes, tick counting and command issue
`default_nettype none

module tblr_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    tblr_in_if.sink               items,
    input  tblr_pkg::fifo_stat_t  stat,
    output logic                  push,
    output tblr_pkg::cmd_t        push_cmd
);

    logic [8:0] tick_reg, tick_next;
    logic [7:0] line_reg, line_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [7:0] scy_reg, scy_next;
    logic [7:0] scx_reg, scx_next;
    logic [7:0] line_inc;
    logic       take;

    assign items.ready = !stat.full;
    assign take        = items.valid && items.ready;
    assign line_inc    = line_reg + 8'd1;

    always_comb
    begin
        tick_next = tick_reg;
        line_next = line_reg;
        ctrl_next = ctrl_reg;
        scy_next  = scy_reg;
        scx_next  = scx_reg;
        push      = 1'b0;

        push_cmd.is_render = 1'b0;
        push_cmd.address   = items.address;
        push_cmd.data      = items.data;
        push_cmd.line      = line_inc;
        push_cmd.scroll_y  = scy_reg;
        push_cmd.first_col = scx_reg[7:3];

        if (take)
        begin
            case (items.operation)
                tblr_pkg::OP_TICK:
                begin
                    if (tick_reg > tblr_pkg::TICK_LIMIT)
                    begin
                        tick_next = '0;
                        line_next = (line_inc > tblr_pkg::LAST_LINE) ? 8'd0 : line_inc;
                        push_cmd.is_render = 1'b1;
                        push_cmd.line      = line_next;
                        push = ctrl_reg[tblr_pkg::DISPLAY_ON_BIT] &&
                               (line_next < tblr_pkg::VISIBLE_LINES);
                    end
                    else
                    begin
                        tick_next = tick_reg + 9'd1;
                    end
                end
                tblr_pkg::OP_VRAM_WR: push = 1'b1;
                tblr_pkg::OP_CTRL_WR: ctrl_next = items.data;
                tblr_pkg::OP_SCY_WR:  scy_next  = items.data;
                tblr_pkg::OP_SCX_WR:  scx_next  = items.data;
                default:              ;   // unknown codes are dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            line_reg <= tblr_pkg::LINE_AT_RESET;
            ctrl_reg <= '0;
            scy_reg  <= '0;
            scx_reg  <= '0;
        end
        else
        begin
            tick_reg <= tick_next;
            line_reg <= line_next;
            ctrl_reg <= ctrl_next;
            scy_reg  <= scy_next;
            scx_reg  <= scx_next;
        end
    end

endmodule

`default_nettype wire

@@ src/tblr_back.sv @@
// back end: video memory, fetch sequencer and result register
`default_nettype none

module tblr_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  tblr_pkg::cmd_t        head,
    input  tblr_pkg::fifo_stat_t  stat,
    output logic                  pop,
    tblr_out_if.source            results
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_TILE,
        ST_LO,
        ST_HI
    } state_t;

    state_t      state_reg;
    logic [7:0]  vram [8192];
    logic [7:0]  rdata_reg;
    logic [12:0] raddr;
    logic        wr_en;

    logic [7:0]  line_reg;
    logic [4:0]  map_row_reg;
    logic [2:0]  fine_reg;
    logic [4:0]  col_reg;
    logic [4:0]  tile_idx_reg;
    logic [7:0]  tile_reg;
    logic [7:0]  lo_reg;
    logic        slot_free;

    logic        out_valid_reg;
    logic [7:0]  out_line_reg;
    logic [4:0]  out_col_reg;
    logic [7:0]  out_mask_reg;
    logic        out_last_reg;

    assign slot_free = !out_valid_reg || results.ready;
    assign pop       = (state_reg == ST_IDLE) && !stat.empty;
    assign wr_en     = pop && !head.is_render;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: raddr = head.address;
            ST_MAP:  raddr = {tblr_pkg::MAP_BASE_HI, 1'b0, map_row_reg, col_reg};
            ST_TILE: raddr = {1'b0, rdata_reg, fine_reg, 1'b0};
            ST_LO:   raddr = {1'b0, tile_reg, fine_reg, 1'b1};
            ST_HI:   raddr = {1'b0, tile_reg, fine_reg, 1'b1};
            default: raddr = head.address;
        endcase
    end

    // single-port video memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vram[head.address] <= head.data;
        end
        rdata_reg <= vram[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in ST_HI the result load below decides the valid flag
            if (out_valid_reg && results.ready && (state_reg != ST_HI))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop && head.is_render)
                    begin
                        line_reg     <= head.line;
                        map_row_reg  <= 5'((head.line + head.scroll_y) >> 3);
                        fine_reg     <= 3'(head.line + head.scroll_y);
                        col_reg      <= head.first_col;
                        tile_idx_reg <= '0;
                        state_reg    <= ST_MAP;
                    end
                end
                ST_MAP:
                begin
                    state_reg <= ST_TILE;
                end
                ST_TILE:
                begin
                    tile_reg  <= rdata_reg;
                    state_reg <= ST_LO;
                end
                ST_LO:
                begin
                    lo_reg    <= rdata_reg;
                    state_reg <= ST_HI;
                end
                ST_HI:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_line_reg  <= line_reg;
                        out_col_reg   <= tile_idx_reg;
                        out_mask_reg  <= lo_reg | rdata_reg;
                        out_last_reg  <= (tile_idx_reg == tblr_pkg::LAST_TILE);
                        tile_idx_reg  <= tile_idx_reg + 5'd1;
                        col_reg       <= col_reg + 5'd1;
                        state_reg     <= (tile_idx_reg == tblr_pkg::LAST_TILE) ?
                                         ST_IDLE : ST_MAP;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.line        = out_line_reg;
    assign results.tile_column = out_col_reg;
    assign results.dark_mask   = out_mask_reg;
    assign results.last        = out_last_reg;

endmodule

`default_nettype wire

@@ src/tile_background_line_renderer_top.sv @@
// top level of the tile background line renderer
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  items    | in  | valid / ready | operation[2:0], address[12:0], data[7:0]
//  results  | out | valid / ready | line[7:0], tile_column[4:0], dark_mask[7:0],
//           |     |               | last
//
// an item is taken whenever the command queue has room; every item, ticks and
// register writes too, waits while the queue is full
// a line render runs the map read, two tile-data reads and the result load for
// each of the 20 tiles of a line, in turn after the command is taken from the
// queue, set by the one memory port
// a memory write waits in the queue and is written by the back end as it is popped
// reset clears counters, the control and scroll registers, the queue and the
// result valid flag; line starts at 144, memory is left as it is
// a stalled result holds the back end in place while the front keeps going
// until the queue fills
`default_nettype none

module tile_background_line_renderer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tblr_in_if.sink     items,
    tblr_out_if.source  results
);

    // commands flow front -> queue -> back in arrival order, so memory writes
    // and renders keep their order while scroll values travel with each render
    tblr_pkg::cmd_t       push_cmd;
    tblr_pkg::cmd_t       head;
    tblr_pkg::fifo_stat_t stat;
    logic                 push;
    logic                 pop;

    tblr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .stat     (stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tblr_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    tblr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .stat    (stat),
        .pop     (pop),
        .results (results)
    );

endmodule

`default_nettype wire

@@ src/tblr_checker.sv @@
// port-level checks on the result channel, bound to the top level
`default_nettype none

module tblr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_line,
    input wire logic [4:0] out_col,
    input wire logic       out_last
);

    logic [4:0] expect_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_col_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            expect_col_reg <= out_last ? 5'd0 : expect_col_reg + 5'd1;
        end
    end

    // a shown result stays, with its column and line, until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_line))
        else $error("result dropped or changed while stalled");

    // tiles of a line arrive in column order from zero
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_col == expect_col_reg)
        else $error("tile column out of sequence");

    // last marks the final tile only
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_last == (out_col == tblr_pkg::LAST_TILE))
        else $error("last flag misplaced");

    // only visible lines are rendered
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_line < tblr_pkg::VISIBLE_LINES)
        else $error("result for a line outside the visible area");

endmodule

bind tile_background_line_renderer_top tblr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_line  (results.line),
    .out_col   (results.tile_column),
    .out_last  (results.last)
);

`default_nettype wire
